FILE: hw/rtl/pttbl_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared types and codes for the periodic timer table.
// ----------------------------------------------------------------------------
package pttbl_pkg;

    localparam int HANDLE_W   = 8;
    localparam int INTERVAL_W = 32;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;

    // At most this many fired timers are reported for one tick.
    localparam int MAX_RESULTS = 8;
    localparam int FIRE_IDX_W  = 3;
    localparam int FIRE_CNT_W  = 4;

    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ATTACH = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DETACH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic [INTERVAL_W-1:0] count;
        logic [INTERVAL_W-1:0] interval;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_EV,
        S_EMIT,
        S_ATTACH,
        S_DET_RD,
        S_DET_EV,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_CLEAR,
        S_RESP
    } t_state;

endpackage

FILE: hw/rtl/periodic_timer_table.sv
// ----------------------------------------------------------------------------
// Periodic timer table
// Holds up to NUM_SLOTS periodic timers; attach, detach and tick them.
// ----------------------------------------------------------------------------
// One word is taken at a time; the input is not ready until every result of
// the previous word has been placed in the output register. The single slot
// memory has one write port and one registered read port, and every slot
// passes through the one 32-bit increment-and-compare unit. A tick walks the
// slots until one with a zero handle or interval, or the last, then emits
// one result per fired timer or one status word; an attach writes the next
// free slot; a detach searches, moves each later slot down by one to close
// the gap and frees the last, or reports the handle not found. After reset
// the table is empty at once: per-slot valid bits make unwritten slots zero.
// ----------------------------------------------------------------------------
module periodic_timer_table #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // handle[7:0], interval[39:8]
    input  logic [1:0]  i_s_axis_tuser,   // action[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // fired_handle[7:0], status[9:8], zero fill
    output logic        o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS    = CNT_W'(NUM_SLOTS);

    // Slot memory and per-slot valid bits.
    pttbl_pkg::t_entry mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;

    pttbl_pkg::t_entry r_rd_entry;
    logic              r_rd_vld;
    pttbl_pkg::t_entry rd_entry;

    pttbl_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_used, n_used;
    logic [pttbl_pkg::FIRE_CNT_W-1:0] r_nfire, n_nfire;
    logic [pttbl_pkg::FIRE_CNT_W-1:0] r_ocnt, n_ocnt;
    logic [pttbl_pkg::HANDLE_W-1:0] r_handle;
    logic [pttbl_pkg::INTERVAL_W-1:0] r_interval;
    logic [pttbl_pkg::STATUS_W-1:0] r_status, n_status;
    logic [pttbl_pkg::HANDLE_W-1:0] r_fire_buf [pttbl_pkg::MAX_RESULTS];

    logic r_out_vld, n_out_vld;
    logic r_out_kind, n_out_kind;
    logic [pttbl_pkg::HANDLE_W-1:0] r_out_handle, n_out_handle;
    logic [pttbl_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic r_out_last, n_out_last;

    logic in_acc;
    logic out_free;
    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    pttbl_pkg::t_entry wr_data;
    logic clr_en;
    logic [IDX_W-1:0] clr_addr;
    logic fire_we;
    logic [pttbl_pkg::INTERVAL_W-1:0] cnt_inc;
    logic cnt_hit;
    logic [CNT_W-1:0] idx_inc;

    assign o_s_axis_tready = (r_state == pttbl_pkg::S_IDLE);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out_status, r_out_handle};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // Slots that were never written, or were freed, read as zero.
    assign rd_entry = r_rd_vld ? r_rd_entry : '0;

    // The shared arithmetic unit: increment a count and compare it.
    assign cnt_inc = rd_entry.count + 32'd1;
    assign cnt_hit = (cnt_inc == rd_entry.interval);
    assign idx_inc = r_idx + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_used       = r_used;
        n_nfire      = r_nfire;
        n_ocnt       = r_ocnt;
        n_status     = r_status;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_handle = r_out_handle;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;
        rd_addr      = r_idx[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_idx[IDX_W-1:0];
        wr_data      = rd_entry;
        clr_en       = 1'b0;
        clr_addr     = r_used[IDX_W-1:0];
        fire_we      = 1'b0;

        unique case (r_state)
            pttbl_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_idx   = '0;
                    n_nfire = '0;
                    n_ocnt  = '0;
                    unique case (i_s_axis_tuser)
                        pttbl_pkg::ACT_TICK:   n_state = pttbl_pkg::S_TICK_RD;
                        pttbl_pkg::ACT_ATTACH: n_state = pttbl_pkg::S_ATTACH;
                        pttbl_pkg::ACT_DETACH: n_state = pttbl_pkg::S_DET_RD;
                        default: begin
                            n_status = pttbl_pkg::ST_OK;
                            n_state  = pttbl_pkg::S_RESP;
                        end
                    endcase
                end
            end

            pttbl_pkg::S_TICK_RD: begin
                rd_en   = 1'b1;
                n_state = pttbl_pkg::S_TICK_EV;
            end

            pttbl_pkg::S_TICK_EV: begin
                if (rd_entry.interval == '0 || rd_entry.handle == '0) begin
                    n_state = pttbl_pkg::S_EMIT;
                end else begin
                    wr_en         = 1'b1;
                    wr_data.count = cnt_hit ? '0 : cnt_inc;
                    if (cnt_hit && r_nfire < pttbl_pkg::FIRE_CNT_W'(pttbl_pkg::MAX_RESULTS)) begin
                        fire_we = 1'b1;
                        n_nfire = r_nfire + 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = pttbl_pkg::S_EMIT;
                    end else begin
                        // Read the next slot while this one is written back.
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[IDX_W-1:0];
                        n_idx   = idx_inc;
                    end
                end
            end

            pttbl_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = pttbl_pkg::ST_OK;
                    if (r_nfire == '0) begin
                        n_out_kind   = pttbl_pkg::KIND_STATUS;
                        n_out_handle = '0;
                        n_out_last   = 1'b1;
                        n_state      = pttbl_pkg::S_IDLE;
                    end else begin
                        n_out_kind   = pttbl_pkg::KIND_FIRED;
                        n_out_handle = r_fire_buf[r_ocnt[pttbl_pkg::FIRE_IDX_W-1:0]];
                        n_out_last   = (r_ocnt + 1'b1 == r_nfire);
                        n_ocnt       = r_ocnt + 1'b1;
                        if (r_ocnt + 1'b1 == r_nfire) begin
                            n_state = pttbl_pkg::S_IDLE;
                        end
                    end
                end
            end

            pttbl_pkg::S_ATTACH: begin
                if (r_used < SLOTS) begin
                    wr_en            = 1'b1;
                    wr_addr          = r_used[IDX_W-1:0];
                    wr_data.handle   = r_handle;
                    wr_data.count    = '0;
                    wr_data.interval = r_interval;
                    n_used           = r_used + 1'b1;
                    n_status         = pttbl_pkg::ST_OK;
                end else begin
                    n_status = pttbl_pkg::ST_FULL;
                end
                n_state = pttbl_pkg::S_RESP;
            end

            pttbl_pkg::S_DET_RD: begin
                if (r_idx >= r_used) begin
                    n_status = pttbl_pkg::ST_NOT_FOUND;
                    n_state  = pttbl_pkg::S_RESP;
                end else begin
                    rd_en   = 1'b1;
                    n_state = pttbl_pkg::S_DET_EV;
                end
            end

            pttbl_pkg::S_DET_EV: begin
                n_idx = idx_inc;
                if (rd_entry.handle == r_handle) begin
                    n_state = pttbl_pkg::S_SHIFT_RD;
                end else begin
                    n_state = pttbl_pkg::S_DET_RD;
                end
            end

            pttbl_pkg::S_SHIFT_RD: begin
                if (r_idx >= r_used) begin
                    n_state = pttbl_pkg::S_CLEAR;
                end else begin
                    rd_en   = 1'b1;
                    n_state = pttbl_pkg::S_SHIFT_WR;
                end
            end

            pttbl_pkg::S_SHIFT_WR: begin
                // Move the entry just read down by one slot.
                wr_en   = 1'b1;
                wr_addr = IDX_W'(r_idx - CNT_W'(1));
                n_idx   = idx_inc;
                n_state = pttbl_pkg::S_SHIFT_RD;
            end

            pttbl_pkg::S_CLEAR: begin
                clr_en   = 1'b1;
                clr_addr = IDX_W'(r_used - CNT_W'(1));
                n_used   = r_used - 1'b1;
                n_status = pttbl_pkg::ST_OK;
                n_state  = pttbl_pkg::S_RESP;
            end

            pttbl_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_kind   = pttbl_pkg::KIND_STATUS;
                    n_out_handle = '0;
                    n_out_status = r_status;
                    n_out_last   = 1'b1;
                    n_state      = pttbl_pkg::S_IDLE;
                end
            end

            default: n_state = pttbl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pttbl_pkg::S_IDLE;
            r_idx     <= '0;
            r_used    <= '0;
            r_nfire   <= '0;
            r_ocnt    <= '0;
            r_out_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_used    <= n_used;
            r_nfire   <= n_nfire;
            r_ocnt    <= n_ocnt;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (clr_en) begin
                r_valid[clr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_handle   <= i_s_axis_tdata[7:0];
            r_interval <= i_s_axis_tdata[39:8];
        end
        r_status     <= n_status;
        r_out_kind   <= n_out_kind;
        r_out_handle <= n_out_handle;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        if (fire_we) begin
            r_fire_buf[r_nfire[pttbl_pkg::FIRE_IDX_W-1:0]] <= rd_entry.handle;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_entry <= mem[rd_addr];
            r_rd_vld   <= r_valid[rd_addr];
        end
    end

endmodule

FILE: tb/sv/periodic_timer_table_checker.sv
// ----------------------------------------------------------------------------
// Periodic timer table checker
// Watches both stream channels of the timer table. Each accepted command
// word updates a private copy of the timer table and queues the result
// words it must cause. Each accepted result word is compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module periodic_timer_table_checker #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,    // handle[7:0], interval[39:8]
    input  logic [1:0]  i_s_tuser,    // action[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // fired_handle[7:0], status[9:8], zero fill
    input  logic        i_m_tuser,    // kind
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic                          kind;
        logic [pttbl_pkg::HANDLE_W-1:0] fired_handle;
        logic [pttbl_pkg::STATUS_W-1:0] status;
        logic                          last;
    } t_timer_report;

    logic [pttbl_pkg::INTERVAL_W-1:0] period_tbl [NUM_SLOTS];
    logic [pttbl_pkg::INTERVAL_W-1:0] elapsed_tbl[NUM_SLOTS];
    logic [pttbl_pkg::HANDLE_W-1:0]   owner_tbl  [NUM_SLOTS];
    int                               occupied;
    t_timer_report                    expected_reports[$];
    int                               mismatch_count = 0;

    function automatic t_timer_report make_report(logic kind,
                                                  logic [pttbl_pkg::HANDLE_W-1:0] h,
                                                  logic [pttbl_pkg::STATUS_W-1:0] st,
                                                  logic last);
        t_timer_report r;
        r.kind         = kind;
        r.fired_handle = h;
        r.status       = st;
        r.last         = last;
        return r;
    endfunction

    task automatic clear_timers();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            period_tbl[s]  = '0;
            elapsed_tbl[s] = '0;
            owner_tbl[s]   = '0;
        end
        occupied = 0;
    endtask

    // The walk stops at the first slot with a zero period or a zero handle.
    task automatic predict_tick();
        logic [pttbl_pkg::HANDLE_W-1:0] fired[$];
        bit                             stop;
        stop = 1'b0;
        for (int s = 0; s < NUM_SLOTS && !stop; s++) begin
            if (period_tbl[s] == '0 || owner_tbl[s] == '0) begin
                stop = 1'b1;
            end else begin
                elapsed_tbl[s] = elapsed_tbl[s] + 1'b1;
                if (elapsed_tbl[s] == period_tbl[s]) begin
                    elapsed_tbl[s] = '0;
                    if (fired.size() < pttbl_pkg::MAX_RESULTS)
                        fired.push_back(owner_tbl[s]);
                end
            end
        end
        if (fired.size() == 0) begin
            expected_reports.push_back(make_report(pttbl_pkg::KIND_STATUS, '0,
                                                   pttbl_pkg::ST_OK, 1'b1));
        end else begin
            foreach (fired[k])
                expected_reports.push_back(make_report(pttbl_pkg::KIND_FIRED, fired[k],
                                                       pttbl_pkg::ST_OK,
                                                       k == fired.size() - 1));
        end
    endtask

    task automatic predict_attach(logic [pttbl_pkg::HANDLE_W-1:0] h,
                                  logic [pttbl_pkg::INTERVAL_W-1:0] period);
        if (occupied < NUM_SLOTS) begin
            period_tbl[occupied]  = period;
            elapsed_tbl[occupied] = '0;
            owner_tbl[occupied]   = h;
            occupied++;
            expected_reports.push_back(make_report(pttbl_pkg::KIND_STATUS, '0,
                                                   pttbl_pkg::ST_OK, 1'b1));
        end else begin
            expected_reports.push_back(make_report(pttbl_pkg::KIND_STATUS, '0,
                                                   pttbl_pkg::ST_FULL, 1'b1));
        end
    endtask

    task automatic predict_detach(logic [pttbl_pkg::HANDLE_W-1:0] h);
        int hit;
        hit = -1;
        for (int s = 0; s < occupied && hit < 0; s++)
            if (owner_tbl[s] == h)
                hit = s;
        if (hit >= 0) begin
            for (int s = hit + 1; s < occupied; s++) begin
                period_tbl[s-1]  = period_tbl[s];
                elapsed_tbl[s-1] = elapsed_tbl[s];
                owner_tbl[s-1]   = owner_tbl[s];
            end
            occupied--;
            period_tbl[occupied]  = '0;
            elapsed_tbl[occupied] = '0;
            owner_tbl[occupied]   = '0;
        end
        expected_reports.push_back(make_report(pttbl_pkg::KIND_STATUS, '0,
                                               (hit >= 0) ? pttbl_pkg::ST_OK :
                                                            pttbl_pkg::ST_NOT_FOUND,
                                               1'b1));
    endtask

    task automatic flag_field(string field, logic [pttbl_pkg::HANDLE_W-1:0] exp_val,
                              logic [pttbl_pkg::HANDLE_W-1:0] act_val);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field,
                 exp_val, act_val);
        mismatch_count++;
    endtask

    task automatic check_report();
        t_timer_report want;
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result word, expected none, got %h/%0b/%0b",
                     $time, i_m_tdata, i_m_tuser, i_m_tlast);
            mismatch_count++;
        end else begin
            want = expected_reports.pop_front();
            if (i_m_tuser !== want.kind)
                flag_field("kind", want.kind, i_m_tuser);
            if (i_m_tdata[7:0] !== want.fired_handle)
                flag_field("fired_handle", want.fired_handle, i_m_tdata[7:0]);
            if (i_m_tdata[9:8] !== want.status)
                flag_field("status", want.status, i_m_tdata[9:8]);
            if (i_m_tlast !== want.last)
                flag_field("last", want.last, i_m_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_timers();
            expected_reports.delete();
        end else begin
            // A result word never belongs to a command word taken on the same edge.
            if (i_m_tvalid && i_m_tready)
                check_report();
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    pttbl_pkg::ACT_TICK:   predict_tick();
                    pttbl_pkg::ACT_ATTACH: predict_attach(i_s_tdata[7:0], i_s_tdata[39:8]);
                    pttbl_pkg::ACT_DETACH: predict_detach(i_s_tdata[7:0]);
                    default: begin
                        expected_reports.push_back(make_report(pttbl_pkg::KIND_STATUS,
                                                               '0, pttbl_pkg::ST_OK,
                                                               1'b1));
                    end
                endcase
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_reports.size();
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Resets the timer table once, runs a directed sequence through empty, full,
// blocked-walk and detach cases, then a long random mix of ticks, attaches
// and detaches with random idling on both channels. A separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [pttbl_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 330;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [39:0] i_s_axis_tdata  = '0;    // handle[7:0], interval[39:8]
    logic [1:0]  i_s_axis_tuser  = '0;    // action[1:0]
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;          // fired_handle[7:0], status[9:8], zero fill
    logic        o_m_axis_tuser;          // kind
    logic        o_m_axis_tlast;

    int mismatches;
    int outstanding;
    int stall_cycles = 0;
    bit steady_phase = 1'b0;

    always #1 i_clk = ~i_clk;

    periodic_timer_table #(
        .NUM_SLOTS(8)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    periodic_timer_table_checker #(
        .NUM_SLOTS(8)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_m_tlast    (o_m_axis_tlast),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    // The result side stalls now and then, except in the steady stretch.
    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && (steady_phase || $urandom_range(99) >= 7);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(logic [pttbl_pkg::ACTION_W-1:0] action,
                             logic [pttbl_pkg::HANDLE_W-1:0] h,
                             logic [pttbl_pkg::INTERVAL_W-1:0] period);
        while (!steady_phase && $urandom_range(99) < 7) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {period, h};
        i_s_axis_tuser  <= action;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly a small pool of handles, so that detaches find their timer.
    function automatic logic [pttbl_pkg::HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return pttbl_pkg::HANDLE_W'($urandom_range(12, 1));
        else if (r < 96)
            return pttbl_pkg::HANDLE_W'($urandom_range(255, 1));
        return '0;
    endfunction

    // Short periods keep timers firing; a zero period blocks the walk.
    function automatic logic [pttbl_pkg::INTERVAL_W-1:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(6, 1);
        else if (r < 92)
            return $urandom_range(40, 7);
        else if (r < 97)
            return $urandom;
        return '0;
    endfunction

    task automatic send_random_word();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_word(pttbl_pkg::ACT_TICK, pttbl_pkg::HANDLE_W'($urandom), $urandom);
        else if (r < 70)
            send_word(pttbl_pkg::ACT_ATTACH, pick_handle(), pick_period());
        else if (r < 95)
            send_word(pttbl_pkg::ACT_DETACH,
                      ($urandom_range(99) < 10) ? '0 : pick_handle(), $urandom);
        else
            send_word(ACT_UNUSED, pttbl_pkg::HANDLE_W'($urandom), $urandom);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table, unknown handle and the unused action code.
        send_word(pttbl_pkg::ACT_TICK, 8'h00, 32'h0);
        send_word(pttbl_pkg::ACT_DETACH, 8'h05, 32'h0);
        send_word(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        // Fastest, slow and longest periods, extreme handles.
        send_word(pttbl_pkg::ACT_ATTACH, 8'h01, 32'd1);
        send_word(pttbl_pkg::ACT_ATTACH, 8'hFF, 32'd2);
        send_word(pttbl_pkg::ACT_ATTACH, 8'h80, 32'hFFFF_FFFF);
        send_word(pttbl_pkg::ACT_TICK, 8'hFF, 32'hFFFF_FFFF);
        send_word(pttbl_pkg::ACT_TICK, 8'h00, 32'h0);
        // A zero handle stops the walk before the timer behind it.
        send_word(pttbl_pkg::ACT_ATTACH, 8'h00, 32'd5);
        send_word(pttbl_pkg::ACT_ATTACH, 8'h07, 32'd1);
        send_word(pttbl_pkg::ACT_TICK, 8'h00, 32'h0);
        send_word(pttbl_pkg::ACT_DETACH, 8'h00, 32'h0);
        send_word(pttbl_pkg::ACT_TICK, 8'h00, 32'h0);
        // A zero period stops the walk too; then fill the table and overflow it.
        send_word(pttbl_pkg::ACT_ATTACH, 8'h09, 32'd0);
        send_word(pttbl_pkg::ACT_ATTACH, 8'h55, 32'd3);
        send_word(pttbl_pkg::ACT_ATTACH, 8'hAA, 32'd1);
        send_word(pttbl_pkg::ACT_ATTACH, 8'h02, 32'd1);
        send_word(pttbl_pkg::ACT_ATTACH, 8'h33, 32'd1);
        send_word(pttbl_pkg::ACT_TICK, 8'h00, 32'h0);
        send_word(pttbl_pkg::ACT_DETACH, 8'h09, 32'h0);
        send_word(pttbl_pkg::ACT_ATTACH, 8'h11, 32'd1);
        send_word(pttbl_pkg::ACT_TICK, 8'h00, 32'h0);
        // Remove the last and the first timer, then a missing one.
        send_word(pttbl_pkg::ACT_DETACH, 8'h11, 32'h0);
        send_word(pttbl_pkg::ACT_DETACH, 8'h01, 32'h0);
        send_word(pttbl_pkg::ACT_DETACH, 8'h42, 32'h0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            steady_phase <= (n >= 120 && n < 200);
            send_random_word();
        end
        i_s_axis_tvalid <= 1'b0;
        steady_phase    <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
